>>> src/dhms_pkg.sv
// ----------------------------------------------------------------------------
// dhms_pkg
// Shared constants, codes and stage types of the duration accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package dhms_pkg;

  localparam int DAY_BITS = 16;

  localparam int SEC_PER_MIN  = 60;
  localparam int MIN_PER_HOUR = 60;
  localparam int HOUR_PER_DAY = 24;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_DAY  = 86400;

  localparam int HOUR_LIMIT = 23;
  localparam int MIN_LIMIT  = 59;
  localparam int SEC_LIMIT  = 59;

  // normalized amount days: 16-bit input plus a carry of at most ten
  localparam int ADAY_W = 17;
  localparam int DSUM_W = ((DAY_BITS > ADAY_W) ? DAY_BITS : ADAY_W) + 1;
  localparam int TOT_W  = 33;
  localparam int TFULL_W = DAY_BITS + 17;

  localparam logic [DAY_BITS-1:0] DAY_MAX = '1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

  // amount after radix normalization, plus load range check
  typedef struct packed {
    op_t               op;
    logic              range_ok;
    logic [ADAY_W-1:0] days;
    logic [4:0]        hours;
    logic [5:0]        minutes;
    logic [5:0]        seconds;
  } amt_t;

  // stored duration after a command, with its status
  typedef struct packed {
    logic [DAY_BITS-1:0] days;
    logic [4:0]          hours;
    logic [5:0]          minutes;
    logic [5:0]          seconds;
    status_t             status;
  } dur_t;

endpackage

`default_nettype wire

>>> src/dhms_cmd_if.sv
// ----------------------------------------------------------------------------
// dhms_cmd_if
// Command channel: op and amount fields with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhms_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] amount_days;
  logic [7:0]  amount_hours;
  logic [7:0]  amount_minutes;
  logic [7:0]  amount_seconds;

  modport source (
    output valid, op, amount_days, amount_hours, amount_minutes, amount_seconds,
    input  ready
  );
  modport sink (
    input  valid, op, amount_days, amount_hours, amount_minutes, amount_seconds,
    output ready
  );
endinterface

`default_nettype wire

>>> src/dhms_res_if.sv
// ----------------------------------------------------------------------------
// dhms_res_if
// Result channel: stored duration, total seconds and status with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhms_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] cur_days;
  logic [4:0]  cur_hours;
  logic [5:0]  cur_minutes;
  logic [5:0]  cur_seconds;
  logic [32:0] total_secs;
  logic [1:0]  status;

  modport source (
    output valid, cur_days, cur_hours, cur_minutes, cur_seconds, total_secs, status,
    input  ready
  );
  modport sink (
    input  valid, cur_days, cur_hours, cur_minutes, cur_seconds, total_secs, status,
    output ready
  );
endinterface

`default_nettype wire

>>> src/dhms_amt_norm.sv
// ----------------------------------------------------------------------------
// dhms_amt_norm
// Input stage: folds amount fields over their radix into carries and
// registers the normalized amount together with the load range check.
// ----------------------------------------------------------------------------
`default_nettype none

module dhms_amt_norm (
  input  logic          clk,
  input  logic          rst,
  dhms_cmd_if.sink      cmd,
  output dhms_pkg::amt_t amt,
  output logic          amt_valid,
  input  logic          amt_ready
);
  import dhms_pkg::*;

  function automatic logic [2:0] quo60(input logic [8:0] v);
    logic [2:0] q;
    q = '0;
    for (int k = 1; k <= 4; k++) begin
      if (v >= 9'(k * SEC_PER_MIN)) q = 3'(k);
    end
    return q;
  endfunction

  function automatic logic [3:0] quo24(input logic [8:0] v);
    logic [3:0] q;
    q = '0;
    for (int k = 1; k <= 10; k++) begin
      if (v >= 9'(k * HOUR_PER_DAY)) q = 4'(k);
    end
    return q;
  endfunction

  logic [2:0] s_q, m_q;
  logic [3:0] h_q;
  logic [8:0] m_v, h_v;
  amt_t       amt_next;

  always_comb begin
    s_q = quo60(9'(cmd.amount_seconds));
    m_v = 9'(cmd.amount_minutes) + 9'(s_q);
    m_q = quo60(m_v);
    h_v = 9'(cmd.amount_hours) + 9'(m_q);
    h_q = quo24(h_v);

    amt_next.op      = op_t'(cmd.op);
    amt_next.seconds = 6'(9'(cmd.amount_seconds) - 9'(s_q) * 9'(SEC_PER_MIN));
    amt_next.minutes = 6'(m_v - 9'(m_q) * 9'(MIN_PER_HOUR));
    amt_next.hours   = 5'(h_v - 9'(h_q) * 9'(HOUR_PER_DAY));
    amt_next.days    = ADAY_W'(cmd.amount_days) + ADAY_W'(h_q);
    amt_next.range_ok = (cmd.amount_hours <= 8'(HOUR_LIMIT)) &&
                        (cmd.amount_minutes <= 8'(MIN_LIMIT)) &&
                        (cmd.amount_seconds <= 8'(SEC_LIMIT)) &&
                        ((32'(cmd.amount_days) >> DAY_BITS) == 32'd0);
  end

  assign cmd.ready = !amt_valid || amt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      amt_valid <= 1'b0;
    end else if (cmd.ready) begin
      amt_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      amt <= amt_next;
    end
  end

endmodule

`default_nettype wire

>>> src/dhms_update.sv
// ----------------------------------------------------------------------------
// dhms_update
// State stage: load, or mixed-radix add or subtract of the normalized amount against
// the stored duration, with range, underflow and overflow checks.
// ----------------------------------------------------------------------------
`default_nettype none

module dhms_update (
  input  logic           clk,
  input  logic           rst,
  input  dhms_pkg::amt_t amt,
  input  logic           amt_valid,
  output logic           amt_ready,
  output dhms_pkg::dur_t dur,
  output logic           dur_valid,
  input  logic           dur_ready
);
  import dhms_pkg::*;

  logic [DAY_BITS-1:0] day_count;
  logic [4:0]          hour_count;
  logic [5:0]          minute_count;
  logic [5:0]          second_count;

  logic                adv;
  dur_t                dur_next;

  logic [6:0]        s_sum, m_sum, s_dif, m_dif;
  logic [5:0]        h_sum, h_dif;
  logic              c0, c1, c2, b0, b1, b2;
  logic [DSUM_W-1:0] d_sum, d_dif;
  logic              over, under;

  always_comb begin
    // add, carry chain
    s_sum = 7'(second_count) + 7'(amt.seconds);
    c0    = s_sum >= 7'(SEC_PER_MIN);
    m_sum = 7'(minute_count) + 7'(amt.minutes) + 7'(c0);
    c1    = m_sum >= 7'(MIN_PER_HOUR);
    h_sum = 6'(hour_count) + 6'(amt.hours) + 6'(c1);
    c2    = h_sum >= 6'(HOUR_PER_DAY);
    d_sum = DSUM_W'(day_count) + DSUM_W'(amt.days) + DSUM_W'(c2);
    over  = d_sum > DSUM_W'(DAY_MAX);

    // subtract, borrow taken from the sign bit of each digit
    s_dif = 7'(second_count) - 7'(amt.seconds);
    b0    = s_dif[6];
    m_dif = 7'(minute_count) - 7'(amt.minutes) - 7'(b0);
    b1    = m_dif[6];
    h_dif = 6'(hour_count) - 6'(amt.hours) - 6'(b1);
    b2    = h_dif[5];
    d_dif = DSUM_W'(day_count) - DSUM_W'(amt.days) - DSUM_W'(b2);
    under = d_dif[DSUM_W-1];

    dur_next.days    = day_count;
    dur_next.hours   = hour_count;
    dur_next.minutes = minute_count;
    dur_next.seconds = second_count;
    dur_next.status  = ST_OK;

    unique case (amt.op)
      OP_LOAD: begin
        if (amt.range_ok) begin
          dur_next.days    = DAY_BITS'(amt.days);
          dur_next.hours   = amt.hours;
          dur_next.minutes = amt.minutes;
          dur_next.seconds = amt.seconds;
        end else begin
          dur_next.status = ST_RANGE;
        end
      end
      OP_ADD: begin
        if (over) begin
          dur_next.status = ST_OVER;
        end else begin
          dur_next.days    = DAY_BITS'(d_sum);
          dur_next.hours   = c2 ? 5'(h_sum - 6'(HOUR_PER_DAY)) : 5'(h_sum);
          dur_next.minutes = c1 ? 6'(m_sum - 7'(MIN_PER_HOUR)) : 6'(m_sum);
          dur_next.seconds = c0 ? 6'(s_sum - 7'(SEC_PER_MIN)) : 6'(s_sum);
        end
      end
      OP_SUB: begin
        if (under) begin
          dur_next.status = ST_UNDER;
        end else begin
          dur_next.days    = DAY_BITS'(d_dif);
          dur_next.hours   = b2 ? 5'(h_dif + 6'(HOUR_PER_DAY)) : 5'(h_dif);
          dur_next.minutes = b1 ? 6'(m_dif + 7'(MIN_PER_HOUR)) : 6'(m_dif);
          dur_next.seconds = b0 ? 6'(s_dif + 7'(SEC_PER_MIN)) : 6'(s_dif);
        end
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign amt_ready = !dur_valid || dur_ready;
  assign adv       = amt_valid && amt_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      day_count    <= '0;
      hour_count   <= '0;
      minute_count <= '0;
      second_count <= '0;
      dur_valid    <= 1'b0;
    end else begin
      if (amt_ready) dur_valid <= amt_valid;
      if (adv) begin
        day_count    <= dur_next.days;
        hour_count   <= dur_next.hours;
        minute_count <= dur_next.minutes;
        second_count <= dur_next.seconds;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dur <= dur_next;
    end
  end

`ifndef SYNTHESIS
  a_state_norm: assert property (@(posedge clk) disable iff (rst)
    hour_count < 5'(HOUR_PER_DAY) && minute_count < 6'(MIN_PER_HOUR) &&
    second_count < 6'(SEC_PER_MIN))
    else $error("stored duration not normalized");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    (adv && dur_next.status != ST_OK) |=>
      ($stable(day_count) && $stable(hour_count) &&
       $stable(minute_count) && $stable(second_count)))
    else $error("rejected command changed the stored duration");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    dur_valid |-> (dur.days == day_count && dur.hours == hour_count &&
                   dur.minutes == minute_count && dur.seconds == second_count))
    else $error("pending result differs from stored duration");

  a_load_taken: assert property (@(posedge clk) disable iff (rst)
    (adv && amt.op == OP_LOAD && amt.range_ok) |=>
      (hour_count == $past(amt.hours) && minute_count == $past(amt.minutes) &&
       second_count == $past(amt.seconds)))
    else $error("valid load not stored");
`endif

endmodule

`default_nettype wire

>>> src/dhms_total.sv
// ----------------------------------------------------------------------------
// dhms_total
// Output stage: converts the stored duration to total seconds and holds
// the result transaction until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dhms_total (
  input  logic           clk,
  input  logic           rst,
  input  dhms_pkg::dur_t dur,
  input  logic           dur_valid,
  output logic           dur_ready,
  dhms_res_if.source     res
);
  import dhms_pkg::*;

  logic               out_valid;
  dur_t               out_dur;
  logic [TOT_W-1:0]   out_total;
  logic [TFULL_W-1:0] total_full;

  always_comb begin
    total_full = TFULL_W'(dur.days) * TFULL_W'(SEC_PER_DAY) +
                 TFULL_W'(dur.hours) * TFULL_W'(SEC_PER_HOUR) +
                 TFULL_W'(dur.minutes) * TFULL_W'(SEC_PER_MIN) +
                 TFULL_W'(dur.seconds);
  end

  assign dur_ready = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dur_ready) begin
      out_valid <= dur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dur_valid && dur_ready) begin
      out_dur   <= dur;
      out_total <= TOT_W'(total_full);
    end
  end

  assign res.valid       = out_valid;
  assign res.cur_days    = 16'(out_dur.days);
  assign res.cur_hours   = out_dur.hours;
  assign res.cur_minutes = out_dur.minutes;
  assign res.cur_seconds = out_dur.seconds;
  assign res.total_secs  = out_total;
  assign res.status      = out_dur.status;

endmodule

`default_nettype wire

>>> src/dhms_duration_accumulator.sv
// ----------------------------------------------------------------------------
// dhms_duration_accumulator
// Days/hours/minutes/seconds duration register with load, add and subtract.
// ----------------------------------------------------------------------------
// Takes one command per clock while no stage is held by backpressure and
// returns one result per command through the normalize, update and output
// registers. The amount is first folded into normalized digits with
// carries, then added to or subtracted from the stored duration digit by
// digit; the stored-state update has no inner register, which sets the
// one-command-per-cycle rate. Total seconds are formed in the output stage.
// Rejected commands (load field out of range, underflow, overflow) report
// their status and leave the stored duration as it was. Each stage holds
// its transaction under backpressure and still fills while later stages wait.
`default_nettype none

module dhms_duration_accumulator (
  input  logic       clk,
  input  logic       rst,
  dhms_cmd_if.sink   cmd,
  dhms_res_if.source res
);
  import dhms_pkg::*;

  amt_t amt;
  logic amt_valid, amt_ready;
  dur_t dur;
  logic dur_valid, dur_ready;

  dhms_amt_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .amt       (amt),
    .amt_valid (amt_valid),
    .amt_ready (amt_ready)
  );

  dhms_update u_update (
    .clk       (clk),
    .rst       (rst),
    .amt       (amt),
    .amt_valid (amt_valid),
    .amt_ready (amt_ready),
    .dur       (dur),
    .dur_valid (dur_valid),
    .dur_ready (dur_ready)
  );

  dhms_total u_total (
    .clk       (clk),
    .rst       (rst),
    .dur       (dur),
    .dur_valid (dur_valid),
    .dur_ready (dur_ready),
    .res       (res)
  );

endmodule

`default_nettype wire
